FILE: design/sek_pkg.sv
// Shared constants, payload types and the exponential table of the kernel pipeline.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package sek_pkg;

   // Table of exp(-k/16), one entry per step of 1/16 in the argument.
   localparam int EXP_TABLE_ENTRIES = 256;

   localparam int COORD_W    = 24;
   localparam int ABS_W      = 24;
   localparam int SQ_W       = 2 * ABS_W;
   localparam int DIST_W     = SQ_W + 1;
   localparam int COEF_W     = 32;
   localparam int VAR_W      = 32;
   localparam int RESULT_W   = 32;
   localparam int DIM_W      = 2;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_INDEX_W = 2;

   // Split of the distance for the two partial products with the coefficient.
   localparam int DIST_LO_W = 32;
   localparam int DIST_HI_W = DIST_W - DIST_LO_W;
   localparam int PP_LO_W   = DIST_LO_W + COEF_W;
   localparam int PP_HI_W   = DIST_HI_W + COEF_W;
   localparam int ARG_W     = DIST_W + COEF_W;

   // Exponent argument: integer part of the table step from bit 44 up, fraction below.
   localparam int INDEX_LSB  = 44;
   localparam int FRAC_LSB   = 12;
   localparam int FRAC_W     = 32;
   localparam int INDEX_W    = $clog2(EXP_TABLE_ENTRIES);
   localparam int ROM_ADDR_W = $clog2(EXP_TABLE_ENTRIES + 1);
   localparam int ARG_TOP_W  = ARG_W - INDEX_LSB;
   localparam logic [ARG_TOP_W-1:0] ARG_LIMIT = ARG_TOP_W'(EXP_TABLE_ENTRIES);

   localparam int EXP_W    = 33;
   localparam int PROD_W   = EXP_W + FRAC_W;
   localparam int SCALED_W = VAR_W + EXP_W;
   localparam logic [31:0] EXP_STEP_Q32 = 32'd4034748382;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_DIMENSIONS     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INV_TWO_LEN_SQ = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_VARIANCE       = 2'd2;

   localparam logic [DIM_W-1:0]  DIMENSIONS_RESET     = 2'd1;
   localparam logic [COEF_W-1:0] INV_TWO_LEN_SQ_RESET = 32'h0000_8000;
   localparam logic [VAR_W-1:0]  VARIANCE_RESET       = 32'h0001_0000;

   typedef logic [EXP_W-1:0] exp_rom_type [0:EXP_TABLE_ENTRIES];

   // Exponent argument as handed from the scaling stage to the table stage.
   typedef struct packed {
      logic                  out_of_range;
      logic [INDEX_W-1:0]    index;
      logic [FRAC_W-1:0]     frac;
   } arg_type;

   // Entry k holds exp(-k/16) in unsigned Q1.32, built by repeated multiplication.
   function automatic exp_rom_type build_exp_rom();
      exp_rom_type       rom;
      logic [PROD_W:0]   prod;
      int                k;
      rom[0] = EXP_W'(64'h1_0000_0000);
      for (k = 1; k <= EXP_TABLE_ENTRIES; k++) begin
         prod = (PROD_W + 1)'(rom[k-1]) * (PROD_W + 1)'(EXP_STEP_Q32)
                + (PROD_W + 1)'(64'h8000_0000);
         rom[k] = prod[32 +: EXP_W];
      end
      return rom;
   endfunction

   localparam exp_rom_type EXP_ROM = build_exp_rom();

endpackage

`default_nettype wire

FILE: design/sek_sqdist.sv
// Squared Euclidean distance of two points over three register stages.
// Depends on sek_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module sek_sqdist (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                two_dim,
   input  logic                                in_valid,
   output logic                                in_stall,
   input  logic signed [sek_pkg::COORD_W-1:0]  first_a,
   input  logic signed [sek_pkg::COORD_W-1:0]  first_b,
   input  logic signed [sek_pkg::COORD_W-1:0]  second_a,
   input  logic signed [sek_pkg::COORD_W-1:0]  second_b,
   output logic                                out_valid,
   input  logic                                out_stall,
   output logic [sek_pkg::DIST_W-1:0]          dist_sq
);
   import sek_pkg::*;

   logic signed [COORD_W:0] diff_a_in;
   logic signed [COORD_W:0] diff_b_in;
   logic [ABS_W-1:0]        abs_a_in;
   logic [ABS_W-1:0]        abs_b_in;
   logic [ABS_W-1:0]        abs_a_ff;
   logic [ABS_W-1:0]        abs_b_ff;
   logic [SQ_W-1:0]         sq_a_ff;
   logic [SQ_W-1:0]         sq_b_ff;
   logic [DIST_W-1:0]       dist_ff;
   logic                    valid1_ff;
   logic                    valid2_ff;
   logic                    valid3_ff;
   logic                    en1;
   logic                    en2;
   logic                    en3;

   // A stage moves when it is empty or when the stage after it moves.
   assign en3      = !valid3_ff || !out_stall;
   assign en2      = !valid2_ff || en3;
   assign en1      = !valid1_ff || en2;
   assign in_stall = !en1;

   assign diff_a_in = $signed({first_a[COORD_W-1], first_a})
                    - $signed({second_a[COORD_W-1], second_a});
   assign diff_b_in = $signed({first_b[COORD_W-1], first_b})
                    - $signed({second_b[COORD_W-1], second_b});

   // The magnitude of a difference stays below 2^24, so the sign bit drops out.
   always_comb begin
      abs_a_in = diff_a_in[COORD_W] ? ABS_W'(-diff_a_in) : diff_a_in[ABS_W-1:0];
      abs_b_in = diff_b_in[COORD_W] ? ABS_W'(-diff_b_in) : diff_b_in[ABS_W-1:0];
      if (!two_dim) begin
         abs_b_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         if (en1) begin
            valid1_ff <= in_valid;
         end
         if (en2) begin
            valid2_ff <= valid1_ff;
         end
         if (en3) begin
            valid3_ff <= valid2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         abs_a_ff <= abs_a_in;
         abs_b_ff <= abs_b_in;
      end
      if (en2) begin
         sq_a_ff <= abs_a_ff * abs_a_ff;
         sq_b_ff <= abs_b_ff * abs_b_ff;
      end
      if (en3) begin
         dist_ff <= DIST_W'(sq_a_ff) + DIST_W'(sq_b_ff);
      end
   end

   assign out_valid = valid3_ff;
   assign dist_sq   = dist_ff;

endmodule

`default_nettype wire

FILE: design/sek_scale.sv
// Scales the squared distance by the coefficient and splits the exponent argument
// into table index and fraction, over two register stages. Depends on sek_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sek_scale (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [sek_pkg::COEF_W-1:0]    coef,
   input  logic                          in_valid,
   output logic                          in_stall,
   input  logic [sek_pkg::DIST_W-1:0]    dist_sq,
   output logic                          out_valid,
   input  logic                          out_stall,
   output sek_pkg::arg_type              arg
);
   import sek_pkg::*;

   logic [PP_LO_W-1:0] pp_lo_ff;
   logic [PP_HI_W-1:0] pp_hi_ff;
   logic [ARG_W-1:0]   product_in;
   arg_type            arg_in;
   arg_type            arg_ff;
   logic               valid1_ff;
   logic               valid2_ff;
   logic               en1;
   logic               en2;

   assign en2      = !valid2_ff || !out_stall;
   assign en1      = !valid1_ff || en2;
   assign in_stall = !en1;

   // The full product is kept, so an argument past 64 bits still reads as out of range.
   assign product_in = ARG_W'(pp_lo_ff) + {pp_hi_ff, DIST_LO_W'(0)};

   always_comb begin
      arg_in.out_of_range = product_in[ARG_W-1:INDEX_LSB] >= ARG_LIMIT;
      arg_in.index        = arg_in.out_of_range ? '0 : product_in[INDEX_LSB +: INDEX_W];
      arg_in.frac         = product_in[FRAC_LSB +: FRAC_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         if (en1) begin
            valid1_ff <= in_valid;
         end
         if (en2) begin
            valid2_ff <= valid1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         pp_lo_ff <= PP_LO_W'(dist_sq[DIST_LO_W-1:0]) * PP_LO_W'(coef);
         pp_hi_ff <= PP_HI_W'(dist_sq[DIST_W-1:DIST_LO_W]) * PP_HI_W'(coef);
      end
      if (en2) begin
         arg_ff <= arg_in;
      end
   end

   assign out_valid = valid2_ff;
   assign arg       = arg_ff;

endmodule

`default_nettype wire

FILE: design/sek_exp.sv
// Table lookup and linear interpolation of exp(-t) over three register stages.
// Depends on sek_pkg for the table and the argument type.
`timescale 1ns / 1ps
`default_nettype none

module sek_exp (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_stall,
   input  sek_pkg::arg_type           arg,
   output logic                       out_valid,
   input  logic                       out_stall,
   output logic [sek_pkg::EXP_W-1:0]  exp_value
);
   import sek_pkg::*;

   logic [ROM_ADDR_W-1:0] addr_hi_in;
   logic [ROM_ADDR_W-1:0] addr_lo_in;
   logic [EXP_W-1:0]      hi_in;
   logic [EXP_W-1:0]      lo_in;
   logic [EXP_W-1:0]      hi1_ff;
   logic [EXP_W-1:0]      step1_ff;
   logic [FRAC_W-1:0]     frac1_ff;
   logic                  oor1_ff;
   logic [EXP_W-1:0]      hi2_ff;
   logic [PROD_W-1:0]     prod_in;
   logic [EXP_W-1:0]      corr2_ff;
   logic                  oor2_ff;
   logic [EXP_W-1:0]      exp3_ff;
   logic                  valid1_ff;
   logic                  valid2_ff;
   logic                  valid3_ff;
   logic                  en1;
   logic                  en2;
   logic                  en3;

   assign en3      = !valid3_ff || !out_stall;
   assign en2      = !valid2_ff || en3;
   assign en1      = !valid1_ff || en2;
   assign in_stall = !en1;

   assign addr_hi_in = ROM_ADDR_W'(arg.index);
   assign addr_lo_in = addr_hi_in + ROM_ADDR_W'(1);
   assign hi_in      = EXP_ROM[addr_hi_in];
   assign lo_in      = EXP_ROM[addr_lo_in];
   assign prod_in    = PROD_W'(step1_ff) * PROD_W'(frac1_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         if (en1) begin
            valid1_ff <= in_valid;
         end
         if (en2) begin
            valid2_ff <= valid1_ff;
         end
         if (en3) begin
            valid3_ff <= valid2_ff;
         end
      end
   end

   // The correction never exceeds the step, so the subtraction cannot wrap.
   // An argument beyond the table gives zero, which makes the final product zero.
   always_ff @(posedge clock) begin
      if (en1) begin
         hi1_ff   <= hi_in;
         step1_ff <= hi_in - lo_in;
         frac1_ff <= arg.frac;
         oor1_ff  <= arg.out_of_range;
      end
      if (en2) begin
         hi2_ff   <= hi1_ff;
         corr2_ff <= prod_in[PROD_W-1:FRAC_W];
         oor2_ff  <= oor1_ff;
      end
      if (en3) begin
         exp3_ff <= oor2_ff ? '0 : hi2_ff - corr2_ff;
      end
   end

   assign out_valid = valid3_ff;
   assign exp_value = exp3_ff;

endmodule

`default_nettype wire

FILE: design/squared_exponential_kernel.sv
// Top level of the squared exponential kernel: registers, pipeline sections and
// the amplitude multiply with rounding. Depends on sek_pkg, sek_sqdist, sek_scale, sek_exp.
//
//   Channel  Ports                                      Moves
//   req      req_valid / req_stall, four coordinates    one pair of points a word
//   rsp      rsp_valid / rsp_stall, rsp_kernel_value    one kernel value a word
//   csr      csr_write, csr_index, csr_data             one register write a cycle
//
// A word enters every cycle while req_stall is low, and passes through ten register
// stages, one for each of: difference, square, sum, partial products, argument, table,
// interpolation product, interpolation subtract, amplitude product and rounding.
// Reset empties the pipeline and loads the register defaults.
// A stall holds only the full stages behind it; empty stages still fill.
`timescale 1ns / 1ps
`default_nettype none

module squared_exponential_kernel (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [sek_pkg::COORD_W-1:0]  req_first_a,
   input  logic signed [sek_pkg::COORD_W-1:0]  req_first_b,
   input  logic signed [sek_pkg::COORD_W-1:0]  req_second_a,
   input  logic signed [sek_pkg::COORD_W-1:0]  req_second_b,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sek_pkg::RESULT_W-1:0]        rsp_kernel_value,
   input  logic                                csr_write,
   input  logic [sek_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [sek_pkg::CSR_DATA_W-1:0]      csr_data
);
   import sek_pkg::*;

   logic [DIM_W-1:0]    dimensions_ff;
   logic [COEF_W-1:0]   coef_ff;
   logic [VAR_W-1:0]    variance_ff;

   logic                dist_valid;
   logic                dist_stall;
   logic [DIST_W-1:0]   dist_sq;
   logic                arg_valid;
   logic                arg_stall;
   arg_type             arg;
   logic                exp_valid;
   logic                exp_stall;
   logic [EXP_W-1:0]    exp_value;

   logic [SCALED_W-1:0] scaled_ff;
   logic [SCALED_W-1:0] rounded_in;
   logic [RESULT_W-1:0] result_in;
   logic [RESULT_W-1:0] result_ff;
   logic                valid1_ff;
   logic                valid2_ff;
   logic                en1;
   logic                en2;

   always_ff @(posedge clock) begin
      if (reset) begin
         dimensions_ff <= DIMENSIONS_RESET;
         coef_ff       <= INV_TWO_LEN_SQ_RESET;
         variance_ff   <= VARIANCE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_DIMENSIONS:     dimensions_ff <= csr_data[DIM_W-1:0];
            CSR_INV_TWO_LEN_SQ: coef_ff       <= csr_data[COEF_W-1:0];
            CSR_VARIANCE:       variance_ff   <= csr_data[VAR_W-1:0];
            default: ;
         endcase
      end
   end

   // Only the upper bit of the dimensions register selects the two-dimensional mode.
   sek_sqdist u_sqdist (
      .clock     (clock),
      .reset     (reset),
      .two_dim   (dimensions_ff[1]),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .first_a   (req_first_a),
      .first_b   (req_first_b),
      .second_a  (req_second_a),
      .second_b  (req_second_b),
      .out_valid (dist_valid),
      .out_stall (dist_stall),
      .dist_sq   (dist_sq)
   );

   sek_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .coef      (coef_ff),
      .in_valid  (dist_valid),
      .in_stall  (dist_stall),
      .dist_sq   (dist_sq),
      .out_valid (arg_valid),
      .out_stall (arg_stall),
      .arg       (arg)
   );

   sek_exp u_exp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (arg_valid),
      .in_stall  (arg_stall),
      .arg       (arg),
      .out_valid (exp_valid),
      .out_stall (exp_stall),
      .exp_value (exp_value)
   );

   assign en2       = !valid2_ff || !rsp_stall;
   assign en1       = !valid1_ff || en2;
   assign exp_stall = !en1;

   // Round to nearest with ties up; the saturation keeps the word within 32 bits.
   assign rounded_in = scaled_ff + SCALED_W'(64'h8000_0000);
   assign result_in  = rounded_in[SCALED_W-1] ? '1 : rounded_in[32 +: RESULT_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         if (en1) begin
            valid1_ff <= exp_valid;
         end
         if (en2) begin
            valid2_ff <= valid1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         scaled_ff <= SCALED_W'(variance_ff) * SCALED_W'(exp_value);
      end
      if (en2) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid        = valid2_ff;
   assign rsp_kernel_value = result_ff;

endmodule

`default_nettype wire
